// ===== rtl/core/mcfir_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfir_pkg
// Shared types and fixed constants of the multichannel FIR filter core:
// field widths, register indexes, coefficient reset values and the
// sequencer state type.
// ----------------------------------------------------------------------------
package mcfir_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W        = 16;
    localparam int COEFF_W         = 16;
    localparam int CH_W            = 3;
    localparam int CNT_W           = 4;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int COEFF_WORDS     = 4;
    localparam int COEFFS_PER_WORD = 4;
    localparam int PROD_W          = SAMPLE_W + COEFF_W;

    // Q2.14 coefficients times Q1.15 samples give Q3.29, back to Q1.15
    localparam int COEFF_FRAC = 14;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_WORD_0  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_WORD_1  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_WORD_2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_WORD_3  = 3'd4;

    // reset values: identity kernel, last tap 1.0 in Q2.14
    localparam logic [CNT_W-1:0]      CHANNEL_COUNT_RST = 4'd1;
    localparam logic [CFG_DATA_W-1:0] COEFF_WORD_RST    = 64'h0;
    localparam logic [CFG_DATA_W-1:0] COEFF_WORD_3_RST  = 64'h4000_0000_0000_0000;

    // result saturation bounds
    localparam int SAT_HI = 32767;
    localparam int SAT_LO = -32768;

    typedef logic [COEFF_WORDS-1:0][CFG_DATA_W-1:0] coeff_bank_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } fir_state_t;

endpackage

// ===== rtl/core/multichannel_fir_filter_core.sv =====
// ----------------------------------------------------------------------------
// multichannel_fir_filter_core
// Direct-form FIR filter over interleaved channels, one history ring per
// channel kept in a synchronous memory, one tap multiplied per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/sample carries interleaved Q1.15 samples,
//   channel 0 to channel_count-1 of a frame, then the next frame. Output
//   channel out_valid/out_stall carries filtered_sample (rounded, saturated
//   Q1.15), the channel of the item and frame_end on the last channel.
//   One result per input item.
//   Throughput: a new item is taken only once the last result is loaded, set
//   by the single read port of the history memory, which delivers one tap per
//   cycle to one multiplier. The core does not enforce the idle rule below.
//   Configuration (cfg_wr_en/cfg_index/cfg_data) is written while idle.
//   Writing channel_count clears all history and restarts at channel 0.
//   Reset: history reads as zero, channel_count is 1 and the kernel is the
//   identity (tap 15 is 1.0). History is cleared through per-entry valid
//   flags, so no clearing pass is needed and items are taken at once.
//   When the receiver stalls the result waits in the output register; the
//   next item is still taken and filtered, and its result is held back, with
//   the input stalled, until that register is free again.
// ----------------------------------------------------------------------------
module multichannel_fir_filter_core
    import mcfir_pkg::*;
#(
    parameter int TAPS         = 16,
    parameter int MAX_CHANNELS = 8
)(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_W-1:0]    sample,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_W-1:0]    filtered_sample,
    output logic [CH_W-1:0]               channel,
    output logic                          frame_end
);

    localparam int TAP_W      = $clog2(TAPS);
    localparam int CHA_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int ADDR_W     = CHA_W + TAP_W;
    localparam int HIST_DEPTH = 1 << ADDR_W;
    localparam int ACC_W      = PROD_W + TAP_W;
    localparam int RND_W      = ACC_W - COEFF_FRAC;

    localparam logic [TAP_W:0]       TAPS_EXT  = (TAP_W + 1)'(TAPS);
    localparam logic [TAP_W-1:0]     TAP_LAST  = TAP_W'(TAPS - 1);
    localparam logic [CNT_W-1:0]     MAX_CH    = CNT_W'(MAX_CHANNELS);
    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(1 << (COEFF_FRAC - 1));
    localparam logic signed [RND_W-1:0] SAT_MAX  = RND_W'(SAT_HI);
    localparam logic signed [RND_W-1:0] SAT_MIN  = RND_W'(SAT_LO);

    // configuration registers
    logic [CNT_W-1:0]   chan_count_reg;
    coeff_bank_t        coeff_reg;

    // frame position
    logic [CH_W-1:0]    ch_cnt_reg;
    logic [TAP_W-1:0]   pos_reg;

    // sequencer and item context
    fir_state_t         state_reg;
    logic [TAP_W-1:0]   tap_reg;
    logic [CH_W-1:0]    item_ch_reg;
    logic [TAP_W-1:0]   item_pos_reg;
    logic               item_last_reg;

    // history memory and its valid flags
    logic [SAMPLE_W-1:0]   hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] hist_vld_reg;

    // read stage
    logic                  rd_vld_reg;
    logic                  rd_last_reg;
    logic [TAP_W-1:0]      rd_tap_reg;
    logic [SAMPLE_W-1:0]   rd_data_reg;
    logic                  rd_hit_reg;

    // multiply stage
    logic                  mul_vld_reg;
    logic                  mul_last_reg;
    logic signed [PROD_W-1:0] prod_reg;

    // accumulate stage
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [SAMPLE_W-1:0]   out_sample_reg;
    logic [CH_W-1:0]              out_ch_reg;
    logic                         out_end_reg;

    logic                   accept;
    logic                   load;
    logic                   chan_cfg_wr;
    logic [CNT_W-1:0]       nch;
    logic [CH_W-1:0]        ch_eff;
    logic                   ch_is_last;
    logic [ADDR_W-1:0]      wr_addr;
    logic [TAP_W:0]         slot_sum;
    logic [TAP_W:0]         slot_wrap;
    logic [ADDR_W-1:0]      rd_addr;
    logic [3:0]             tap_sel;
    logic signed [COEFF_W-1:0]  coeff_sel;
    logic signed [SAMPLE_W-1:0] hist_sample;
    logic signed [ACC_W-1:0]    biased;
    logic signed [RND_W-1:0]    rounded;
    logic signed [SAMPLE_W-1:0] sat_result;

    // handshakes
    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign load        = done_reg && (!out_valid_reg || !out_stall);
    assign chan_cfg_wr = cfg_wr_en && (cfg_index == REG_CHANNEL_COUNT);

    // active channel count, zero means one, clamped to the maximum
    always_comb
    begin
        if (chan_count_reg == '0)
            nch = CNT_W'(1);
        else if (chan_count_reg > MAX_CH)
            nch = MAX_CH;
        else
            nch = chan_count_reg;
    end

    // channel of the incoming item and end of frame
    assign ch_eff     = ({1'b0, ch_cnt_reg} >= nch) ? '0 : ch_cnt_reg;
    assign ch_is_last = (({1'b0, ch_eff} + CNT_W'(1)) >= nch);
    assign wr_addr    = {ch_eff[CHA_W-1:0], pos_reg};

    // ring slot for the tap being issued, oldest sample first
    always_comb
    begin
        slot_sum  = {1'b0, item_pos_reg} + {1'b0, tap_reg} + (TAP_W + 1)'(1);
        slot_wrap = (slot_sum >= TAPS_EXT) ? (slot_sum - TAPS_EXT) : slot_sum;
    end
    assign rd_addr = {item_ch_reg[CHA_W-1:0], slot_wrap[TAP_W-1:0]};

    // coefficient of the tap in the read stage
    assign tap_sel     = 4'(rd_tap_reg);
    assign coeff_sel   = coeff_reg[tap_sel[3:2]][tap_sel[1:0]*COEFF_W +: COEFF_W];
    assign hist_sample = rd_hit_reg ? rd_data_reg : '0;

    // round half up and saturate
    always_comb
    begin
        biased  = acc_reg + RND_BIAS;
        rounded = biased[ACC_W-1:COEFF_FRAC];
        if (rounded > SAT_MAX)
            sat_result = SAT_MAX[SAMPLE_W-1:0];
        else if (rounded < SAT_MIN)
            sat_result = SAT_MIN[SAMPLE_W-1:0];
        else
            sat_result = rounded[SAMPLE_W-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_count_reg <= CHANNEL_COUNT_RST;
            coeff_reg[0]   <= COEFF_WORD_RST;
            coeff_reg[1]   <= COEFF_WORD_RST;
            coeff_reg[2]   <= COEFF_WORD_RST;
            coeff_reg[3]   <= COEFF_WORD_3_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: chan_count_reg <= cfg_data[CNT_W-1:0];
                REG_COEFF_WORD_0:  coeff_reg[0]   <= cfg_data;
                REG_COEFF_WORD_1:  coeff_reg[1]   <= cfg_data;
                REG_COEFF_WORD_2:  coeff_reg[2]   <= cfg_data;
                REG_COEFF_WORD_3:  coeff_reg[3]   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // frame position and history valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_cnt_reg   <= '0;
            pos_reg      <= '0;
            hist_vld_reg <= '0;
        end
        else if (chan_cfg_wr)
        begin
            ch_cnt_reg   <= '0;
            pos_reg      <= '0;
            hist_vld_reg <= '0;
        end
        else if (accept)
        begin
            hist_vld_reg[wr_addr] <= 1'b1;
            if (ch_is_last)
            begin
                ch_cnt_reg <= '0;
                pos_reg    <= (pos_reg == TAP_LAST) ? '0 : pos_reg + TAP_W'(1);
            end
            else
            begin
                ch_cnt_reg <= ch_eff + CH_W'(1);
            end
        end
    end

    // history memory: new sample written at accept, taps read after it,
    // so the newest tap always sees the sample just written
    always_ff @(posedge clk)
    begin
        if (accept)
            hist_mem[wr_addr] <= sample;
        rd_data_reg <= hist_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tap_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    tap_reg <= '0;
                    if (accept)
                        state_reg <= S_RUN;
                end
                S_RUN:
                begin
                    tap_reg <= tap_reg + TAP_W'(1);
                    if (tap_reg == TAP_LAST)
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    if (load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // item context
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_ch_reg   <= ch_eff;
            item_pos_reg  <= pos_reg;
            item_last_reg <= ch_is_last;
        end
    end

    // read and multiply stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg   <= 1'b0;
            rd_last_reg  <= 1'b0;
            mul_vld_reg  <= 1'b0;
            mul_last_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            rd_vld_reg   <= (state_reg == S_RUN);
            rd_last_reg  <= (state_reg == S_RUN) && (tap_reg == TAP_LAST);
            mul_vld_reg  <= rd_vld_reg;
            mul_last_reg <= rd_last_reg;
            if (mul_last_reg)
                done_reg <= 1'b1;
            else if (load)
                done_reg <= 1'b0;
        end
    end

    // read and multiply stage data
    always_ff @(posedge clk)
    begin
        rd_tap_reg <= tap_reg;
        rd_hit_reg <= hist_vld_reg[rd_addr];
        prod_reg   <= coeff_sel * hist_sample;
    end

    // accumulator
    always_ff @(posedge clk)
    begin
        if (accept)
            acc_reg <= '0;
        else if (mul_vld_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_sample_reg <= sat_result;
            out_ch_reg     <= item_ch_reg;
            out_end_reg    <= item_last_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign filtered_sample = out_sample_reg;
    assign channel         = out_ch_reg;
    assign frame_end       = out_end_reg;

    // checks
    property p_tap_in_range;
        @(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (tap_reg <= TAP_LAST);
    endproperty
    a_tap_in_range: assert property (p_tap_in_range)
        else $error("tap counter beyond last tap");

    property p_load_pipe_empty;
        @(posedge clk) disable iff (!rst_n)
        load |-> (!rd_vld_reg && !mul_vld_reg && (state_reg == S_DRAIN));
    endproperty
    a_load_pipe_empty: assert property (p_load_pipe_empty)
        else $error("result loaded while taps still in flight");

    property p_accept_clean;
        @(posedge clk) disable iff (!rst_n)
        accept |-> (!done_reg && !rd_vld_reg && !mul_vld_reg);
    endproperty
    a_accept_clean: assert property (p_accept_clean)
        else $error("item accepted while previous item still in progress");

    property p_done_after_last;
        @(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(mul_last_reg);
    endproperty
    a_done_after_last: assert property (p_done_after_last)
        else $error("result marked done before last product");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multichannel FIR filter core. A driver sends
// interleaved samples from a queue and a monitor compares every filtered
// item with a bit-true prediction made when the sample is taken. Phases
// change the channel count and the coefficient words while the core is
// idle, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    import mcfir_pkg::*;

    localparam int TAPS_N        = 16;
    localparam int MAX_CH        = 8;
    localparam int SETTLE_CYCLES = TAPS_N + 4;
    localparam int QUIET_LIMIT   = 4000;
    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_PHASES = 8;
    localparam int CHUNK_ITEMS   = 30;

    // first register index past the end of the list
    localparam logic [CFG_IDX_W-1:0] REG_BEYOND_LAST = REG_COEFF_WORD_3 + 3'd1;

    typedef enum int {
        COEFF_FULL,
        COEFF_SMALL,
        COEFF_EXTREME,
        COEFF_SPARSE
    } coeff_style_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [CH_W-1:0]     chan;
        logic                last;
    } filter_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] filtered_sample;
    logic [CH_W-1:0]            channel;
    logic                       frame_end;

    // filter state as the core should hold it
    logic signed [SAMPLE_W-1:0] hist_ring [MAX_CH][TAPS_N];
    int unsigned                ring_slot;
    int unsigned                next_chan;
    logic [CNT_W-1:0]           chan_count_reg;
    coeff_bank_t                coeff_bank;

    logic signed [SAMPLE_W-1:0] samples_to_send [$];
    filter_result_t             filter_outputs_due [$];
    filter_result_t             head_result;

    int  send_gap = 0;
    int  stall_left = 0;
    bit  idling_on = 1'b1;
    int  mismatch_count = 0;
    int  quiet_cycles = 0;

    multichannel_fir_filter_core #(
        .TAPS         (TAPS_N),
        .MAX_CHANNELS (MAX_CH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .filtered_sample (filtered_sample),
        .channel         (channel),
        .frame_end       (frame_end)
    );

    // clock
    always
    begin
        #4 clk = ~clk;
    end

    // wipe all rings and restart at channel 0, slot 0
    function automatic void clear_fir_history();
        for (int c = 0; c < MAX_CH; c++)
        begin
            for (int t = 0; t < TAPS_N; t++)
                hist_ring[c][t] = '0;
        end
        ring_slot = 0;
        next_chan = 0;
    endfunction

    // filter one taken sample and queue the item it should produce
    function automatic void compute_fir_output(input logic signed [SAMPLE_W-1:0] x);
        int unsigned                active;
        int unsigned                ch;
        int unsigned                slot;
        longint                     acc;
        longint                     rounded;
        logic [CFG_DATA_W-1:0]      word;
        logic signed [COEFF_W-1:0]  coeff;
        filter_result_t             r;
        active = (chan_count_reg == 0) ? 1 :
                 (chan_count_reg > MAX_CH) ? MAX_CH : chan_count_reg;
        ch = (next_chan >= active) ? 0 : next_chan;
        hist_ring[ch][ring_slot] = x;
        acc = 0;
        // tap TAPS-1 weights the newest sample
        for (int k = 0; k < TAPS_N; k++)
        begin
            slot  = (ring_slot + 1 + k) % TAPS_N;
            word  = coeff_bank[k / COEFFS_PER_WORD];
            coeff = word[COEFF_W * (k % COEFFS_PER_WORD) +: COEFF_W];
            acc   = acc + longint'(coeff) * longint'(hist_ring[ch][slot]);
        end
        // round half up, then saturate
        rounded = (acc + (64'sd1 <<< (COEFF_FRAC - 1))) >>> COEFF_FRAC;
        if (rounded > SAT_HI)
            rounded = SAT_HI;
        if (rounded < SAT_LO)
            rounded = SAT_LO;
        r.value = rounded[SAMPLE_W-1:0];
        r.chan  = ch[CH_W-1:0];
        r.last  = (ch + 1 >= active);
        filter_outputs_due.push_back(r);
        if (r.last)
        begin
            next_chan = 0;
            ring_slot = (ring_slot + 1) % TAPS_N;
        end
        else
            next_chan = ch + 1;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        if (pick == 0)
            return 16'sh7FFF;
        else if (pick == 1)
            return 16'sh8000;
        else if (pick < 5)
            return 16'($urandom_range(0, 511)) - 16'd256;
        else
            return 16'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_coeff_word();
        logic [CFG_DATA_W-1:0] w;
        logic [COEFF_W-1:0]    c;
        coeff_style_t          style;
        style = coeff_style_t'($urandom_range(0, 3));
        for (int t = 0; t < COEFFS_PER_WORD; t++)
        begin
            case (style)
                COEFF_FULL:    c = 16'($urandom);
                COEFF_SMALL:   c = 16'($urandom_range(0, 2047)) - 16'd1024;
                COEFF_EXTREME: c = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                default:       c = ($urandom_range(0, 3) == 0) ?
                                   16'($urandom_range(0, 16383)) : 16'h0;
            endcase
            w[COEFF_W*t +: COEFF_W] = c;
        end
        return w;
    endfunction

    // one register write, mirrored into the predicted state
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_CHANNEL_COUNT:
            begin
                chan_count_reg = val[CNT_W-1:0];
                clear_fir_history();
            end
            REG_COEFF_WORD_0, REG_COEFF_WORD_1, REG_COEFF_WORD_2, REG_COEFF_WORD_3:
                coeff_bank[idx - REG_COEFF_WORD_0] = val;
            default:
                ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // hold until every queued sample is sent and every item has come back
    task automatic wait_drained();
        @(negedge clk);
        while (samples_to_send.size() != 0 || in_valid || filter_outputs_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random_samples(input int n);
        @(negedge clk);
        repeat (n) samples_to_send.push_back(random_sample());
    endtask

    // driver: take the accepted item, then present the next one
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                compute_fir_output(sample);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (samples_to_send.size() != 0)
                begin
                    in_valid <= 1'b1;
                    sample   <= samples_to_send.pop_front();
                    if (idling_on && $urandom_range(0, 2) == 0)
                        send_gap = $urandom_range(1, 14);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each filtered item with the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (filter_outputs_due.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual %0d ch %0d end %0d",
                             $time, filtered_sample, channel, frame_end);
                    mismatch_count++;
                end
                else
                begin
                    head_result = filter_outputs_due.pop_front();
                    if (filtered_sample !== $signed(head_result.value))
                    begin
                        $display("%0t: filtered_sample mismatch: expected %0d, actual %0d",
                                 $time, $signed(head_result.value), filtered_sample);
                        mismatch_count++;
                    end
                    if (channel !== head_result.chan)
                    begin
                        $display("%0t: channel mismatch: expected %0d, actual %0d",
                                 $time, head_result.chan, channel);
                        mismatch_count++;
                    end
                    if (frame_end !== head_result.last)
                    begin
                        $display("%0t: frame_end mismatch: expected %0d, actual %0d",
                                 $time, head_result.last, frame_end);
                        mismatch_count++;
                    end
                end
            end
            // stall in random bursts
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        chan_count_reg = CHANNEL_COUNT_RST;
        coeff_bank[0]  = COEFF_WORD_RST;
        coeff_bank[1]  = COEFF_WORD_RST;
        coeff_bank[2]  = COEFF_WORD_RST;
        coeff_bank[3]  = COEFF_WORD_3_RST;
        clear_fir_history();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // writes past the register list leave the reset kernel alone
        for (int i = REG_BEYOND_LAST; i < (1 << CFG_IDX_W); i++)
            write_reg(CFG_IDX_W'(i), {$urandom, $urandom});

        // identity kernel on one channel: extremes pass straight through
        @(negedge clk);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh0000);
        samples_to_send.push_back(16'sh0001);
        samples_to_send.push_back(16'shFFFF);
        samples_to_send.push_back(16'sh5555);
        samples_to_send.push_back(16'shAAAA);
        wait_drained();
        settle();

        // two channels, all taps near +2.0: saturation at both ends
        write_reg(REG_CHANNEL_COUNT, 64'd2);
        write_reg(REG_COEFF_WORD_0, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_COEFF_WORD_1, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_COEFF_WORD_2, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(REG_COEFF_WORD_3, 64'h7FFF_7FFF_7FFF_7FFF);
        @(negedge clk);
        repeat (4) samples_to_send.push_back(16'sh7FFF);
        repeat (6) samples_to_send.push_back(16'sh8000);
        wait_drained();
        settle();

        // channel count zero acts as one, newest tap at -2.0
        write_reg(REG_CHANNEL_COUNT, 64'd0);
        write_reg(REG_COEFF_WORD_0, 64'h0);
        write_reg(REG_COEFF_WORD_1, 64'h0);
        write_reg(REG_COEFF_WORD_2, 64'h0);
        write_reg(REG_COEFF_WORD_3, 64'h8000_0000_0000_0000);
        @(negedge clk);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh8000);
        wait_drained();
        settle();

        // count above the maximum acts as eight; half gain checks rounding
        write_reg(REG_CHANNEL_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_COEFF_WORD_3, 64'h2000_0000_0000_0000);
        @(negedge clk);
        samples_to_send.push_back(16'sh0001);
        samples_to_send.push_back(16'shFFFF);
        samples_to_send.push_back(16'sh0003);
        samples_to_send.push_back(16'shFFFD);
        samples_to_send.push_back(16'sh7FFF);
        samples_to_send.push_back(16'sh8000);
        samples_to_send.push_back(16'sh0002);
        samples_to_send.push_back(16'shFFFE);
        wait_drained();
        settle();

        // random phases; some keep history across coefficient changes
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idling_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (ph == 0)
                write_reg(REG_CHANNEL_COUNT, 64'd1);
            else if (ph == 1)
                write_reg(REG_CHANNEL_COUNT, 64'd8);
            else if ($urandom_range(0, 1) == 1)
                write_reg(REG_CHANNEL_COUNT, {$urandom, $urandom});
            for (int w = 0; w < COEFF_WORDS; w++)
            begin
                if (ph < 2 || $urandom_range(0, 3) != 0)
                    write_reg(CFG_IDX_W'(REG_COEFF_WORD_0 + w), random_coeff_word());
            end
            queue_random_samples(CHUNK_ITEMS);
            // in some phases the sender holds off until the core has emptied
            if (ph == 2 || $urandom_range(0, 1) == 1)
                wait_drained();
            queue_random_samples(CHUNK_ITEMS);
            wait_drained();
            settle();
        end

        if (mismatch_count == 0 && filter_outputs_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/mcfir_pkg.sv
rtl/core/multichannel_fir_filter_core.sv
tb/sv/tb_top.sv
